/* sv/pcalu_pkg.sv */
// Shared types, constants and helper functions for the polar complex ALU.
package pcalu_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned GUARD            = 8;
  localparam int unsigned XW               = 48;   // CORDIC x/y width, guard bits included
  localparam int unsigned ZW               = 34;   // CORDIC angle accumulator width
  localparam int unsigned QDEPTH           = 4;
  localparam int unsigned IN_TDATA_W       = 160;
  localparam int unsigned IN_TUSER_W       = 3;
  localparam int unsigned OUT_TDATA_W      = 112;
  localparam int unsigned OUT_TUSER_W      = 1;

  localparam logic [31:0] KGAIN = 32'd2608131496;  // 1/CORDIC gain, Q32

  localparam logic signed [ZW-1:0] QTR_TURN  = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);
  localparam logic signed [XW-1:0] RND_G     = XW'(64'd1 << (GUARD - 1));
  localparam logic signed [XW-1:0] S32_MAX   = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] S32_MIN   = -(XW'(64'sd2147483648));

  localparam logic [31:0] ATAN_TURN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_SUB    = 3'd1,
    KIND_MUL    = 3'd2,
    KIND_DIV    = 3'd3,
    KIND_NEG    = 3'd4,
    KIND_ADDRE  = 3'd5,
    KIND_RECT   = 3'd6,
    KIND_RENORM = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] a_mag;
    logic [15:0] a_ang;
    logic [31:0] b_mag;
    logic [15:0] b_ang;
    logic [31:0] in_re;
    logic [31:0] in_im;
  } item_t;

  // direct: mul/div/negate skip the CORDIC combine path
  typedef struct packed {
    logic direct;
    logic is_div;
  } cls_t;

  typedef struct packed {
    item_t item;
    cls_t  cls;
  } qent_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // magnitude/angle to rotator start point: gain-compensated x, folded to +-quarter turn
  function automatic vec_t prerot(input logic [31:0] mag, input logic [15:0] ang);
    logic [63:0]          p;
    vec_t                 v;
    logic signed [ZW-1:0] z;
    p   = 64'(mag) * 64'(KGAIN);
    v.x = signed'(XW'(p[63:24]));
    v.y = '0;
    z   = ZW'($signed({ang, 16'h0000}));
    if (z > QTR_TURN) begin
      v.x = -v.x;
      z   = z - HALF_TURN;
    end else if (z < -QTR_TURN) begin
      v.x = -v.x;
      z   = z + HALF_TURN;
    end
    v.z = z;
    return v;
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [XW-1:0] g);
    logic signed [XW-1:0] r;
    logic [31:0]          s;
    r = (g + RND_G) >>> GUARD;
    if (r > S32_MAX) begin
      s = 32'h7FFF_FFFF;
    end else if (r < S32_MIN) begin
      s = 32'h8000_0000;
    end else begin
      s = r[31:0];
    end
    return s;
  endfunction

endpackage

/* sv/polar_complex_alu.sv */
// Polar complex ALU top level: request queue in front of a fully pipelined datapath.
// Takes one request per clock and returns one result per clock, in order, while the output
// is not stalled. The datapath is built from the restoring divider (one quotient bit per
// stage) and the unrolled CORDIC rotators, vectoring unit and final rotator (one step per
// stage). A four-entry input queue keeps s_axis_tready_o high while the output is stalled
// until the queue fills; a stall at the output freezes the whole datapath.
module polar_complex_alu import pcalu_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // a_mag, a_ang, b_mag, b_ang, in_re, in_im
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // res_mag, res_ang, res_re, res_im
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // zero_divisor
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  qent_t       head;
  logic        head_vld, pop, zdiv;
  logic [31:0] res_mag, res_re, res_im;
  logic [15:0] res_ang;

  pcalu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .head_o         (head),
    .head_vld_o     (head_vld),
    .pop_i          (pop)
  );

  pcalu_back #(.STEPS(CORDIC_STEPS), .FRAC(FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .head_vld_i(head_vld),
    .pop_o     (pop),
    .m_vld_o   (m_axis_tvalid_o),
    .m_rdy_i   (m_axis_tready_i),
    .res_mag_o (res_mag),
    .res_ang_o (res_ang),
    .res_re_o  (res_re),
    .res_im_o  (res_im),
    .zdiv_o    (zdiv)
  );

  assign m_axis_tdata_o = {res_im, res_re, res_ang, res_mag};
  assign m_axis_tuser_o = zdiv;

endmodule

/* sv/pcalu_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module pcalu_front import pcalu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [IN_TUSER_W-1:0] s_axis_tuser_i,
  output qent_t                 head_o,
  output logic                  head_vld_o,
  input  logic                  pop_i
);

  localparam int unsigned QAW = $clog2(QDEPTH);

  qent_t          mem_q [QDEPTH];
  qent_t          ent;
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           push;

  always_comb begin
    ent.item.kind  = kind_e'(s_axis_tuser_i);
    ent.item.a_mag = s_axis_tdata_i[31:0];
    ent.item.a_ang = s_axis_tdata_i[47:32];
    ent.item.b_mag = s_axis_tdata_i[79:48];
    ent.item.b_ang = s_axis_tdata_i[95:80];
    ent.item.in_re = s_axis_tdata_i[127:96];
    ent.item.in_im = s_axis_tdata_i[159:128];
    ent.cls.direct = (ent.item.kind == KIND_MUL) || (ent.item.kind == KIND_DIV) ||
                     (ent.item.kind == KIND_NEG);
    ent.cls.is_div = (ent.item.kind == KIND_DIV);
  end

  assign s_axis_tready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign head_vld_o      = (cnt_q != '0);
  assign head_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QAW+1)'(push) - (QAW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

endmodule

/* sv/pcalu_pipe.sv */
// Enabled delay line for side data that travels alongside the arithmetic stages.
module pcalu_pipe #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (DEPTH == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_sr
    logic [W-1:0] sr_q [DEPTH];
    for (genvar i = 0; i < DEPTH; i++) begin : g_tap
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sr_q[i] <= (i == 0) ? d_i : sr_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
    assign q_o = sr_q[DEPTH-1];
  end

endmodule

/* sv/pcalu_cordic.sv */
// Unrolled CORDIC, one micro-rotation per register stage; rotation or vectoring mode.
module pcalu_cordic import pcalu_pkg::*; #(
  parameter int unsigned STEPS = CORDIC_STEPS_DEF,
  parameter bit          VECT  = 1'b0
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t v_i,
  output vec_t v_o
);

  vec_t st_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    vec_t                 cur, nxt;
    logic signed [ZW-1:0] at;
    logic                 pos;

    if (i == 0) begin : g_first
      assign cur = v_i;
    end else begin : g_next
      assign cur = st_q[i-1];
    end

    assign at = signed'(ZW'(ATAN_TURN[i]));

    always_comb begin
      // rotate toward z = 0, or toward y = 0 when vectoring
      pos = VECT ? cur.y[XW-1] : ~cur.z[ZW-1];
      if (pos) begin
        nxt.x = cur.x - (cur.y >>> i);
        nxt.y = cur.y + (cur.x >>> i);
        nxt.z = cur.z - at;
      end else begin
        nxt.x = cur.x + (cur.y >>> i);
        nxt.y = cur.y - (cur.x >>> i);
        nxt.z = cur.z + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign v_o = st_q[STEPS-1];

endmodule

/* sv/pcalu_div.sv */
// Pipelined restoring divider: (num << FRAC) / den, one quotient bit per stage.
module pcalu_div #(
  parameter int unsigned FRAC = 16,
  localparam int unsigned DW  = 32 + FRAC
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [31:0]   num_i,
  input  logic [31:0]   den_i,
  output logic [DW-1:0] quo_o
);

  typedef struct packed {
    logic [31:0]   rem;
    logic [DW-1:0] quo;
    logic [DW-1:0] dvd;
    logic [31:0]   den;
  } dstage_t;

  dstage_t st_q [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    dstage_t     cur, nxt;
    logic [32:0] r;
    logic        ge;

    if (i == 0) begin : g_first
      always_comb begin
        cur.rem = '0;
        cur.quo = '0;
        cur.dvd = {num_i, FRAC'(0)};
        cur.den = den_i;
      end
    end else begin : g_next
      assign cur = st_q[i-1];
    end

    always_comb begin
      r       = {cur.rem, cur.dvd[DW-1]};
      ge      = (r >= {1'b0, cur.den});
      nxt.rem = ge ? 32'(r - {1'b0, cur.den}) : r[31:0];
      nxt.quo = {cur.quo[DW-2:0], ge};
      nxt.dvd = cur.dvd << 1;
      nxt.den = cur.den;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign quo_o = st_q[DW-1].quo;

endmodule

/* sv/pcalu_back.sv */
// Back end: fixed-latency datapath for all operations, stalled as a whole by the output.
module pcalu_back import pcalu_pkg::*; #(
  parameter int unsigned STEPS = CORDIC_STEPS_DEF,
  parameter int unsigned FRAC  = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qent_t       head_i,
  input  logic        head_vld_i,
  output logic        pop_o,
  output logic        m_vld_o,
  input  logic        m_rdy_i,
  output logic [31:0] res_mag_o,
  output logic [15:0] res_ang_o,
  output logic [31:0] res_re_o,
  output logic [31:0] res_im_o,
  output logic        zdiv_o
);

  localparam int unsigned DW = 32 + FRAC;
  localparam int unsigned LC = 2 * STEPS + 5;        // CORDIC add/sub path
  localparam int unsigned LM = (LC > DW) ? LC : DW;  // both paths aligned here
  localparam int unsigned LT = LM + STEPS + 4;       // valid chain length

  typedef struct packed {
    kind_e       kind;
    logic [31:0] in_re;
    logic [31:0] in_im;
  } cside_t;

  typedef struct packed {
    logic [63:0] p1;
    logic [47:0] p2;
    logic [31:0] turn;
  } mk1_t;

  typedef struct packed {
    logic [31:0] mag;
    logic [15:0] ang;
  } pol_t;

  typedef struct packed {
    logic        direct;
    logic        is_div;
    logic        zdiv;
    logic [31:0] mag;
    logic [15:0] ang;
  } dside_t;

  typedef struct packed {
    dside_t        ds;
    logic [DW-1:0] quo;
  } dres_t;

  typedef struct packed {
    pol_t pol;
    logic zdiv;
  } mres_t;

  logic          en;
  logic [LT-1:0] vld_q;
  qent_t         s0_q;
  vec_t          pa_q, pb_q, ra, rb, c_q, c_d, vf_q, vf_d, rv, f_q, rf;
  cside_t        cs0, cs;
  mk1_t          mk1_q, mk1_d;
  pol_t          mk2_q, mk2_d, cpol;
  dside_t        d1_q, d1_d, ds_al;
  logic [DW-1:0] quo;
  dres_t         dres_in, dres;
  mres_t         m_q, m_d, m_al;
  logic          [31:0] o_mag_q, o_re_q, o_im_q;
  logic          [15:0] o_ang_q;
  logic          o_zdiv_q;

  assign en      = !vld_q[LT-1] || m_rdy_i;
  assign pop_o   = en && head_vld_i;
  assign m_vld_o = vld_q[LT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LT-2:0], head_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s0_q <= head_i;
    end
  end

  // ---------------- CORDIC path ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= prerot(s0_q.item.a_mag, s0_q.item.a_ang);
      pb_q <= prerot(s0_q.item.b_mag, s0_q.item.b_ang);
    end
  end

  pcalu_cordic #(.STEPS(STEPS), .VECT(1'b0)) u_rot_a (
    .clk_i(clk_i), .en_i(en), .v_i(pa_q), .v_o(ra)
  );

  pcalu_cordic #(.STEPS(STEPS), .VECT(1'b0)) u_rot_b (
    .clk_i(clk_i), .en_i(en), .v_i(pb_q), .v_o(rb)
  );

  assign cs0.kind  = s0_q.item.kind;
  assign cs0.in_re = s0_q.item.in_re;
  assign cs0.in_im = s0_q.item.in_im;

  pcalu_pipe #(.W($bits(cside_t)), .DEPTH(STEPS + 1)) u_cside (
    .clk_i(clk_i), .en_i(en), .d_i(cs0), .q_o(cs)
  );

  always_comb begin
    c_d = ra;
    case (cs.kind)
      KIND_ADD: begin
        c_d.x = ra.x + rb.x;
        c_d.y = ra.y + rb.y;
      end
      KIND_SUB: begin
        c_d.x = ra.x - rb.x;
        c_d.y = ra.y - rb.y;
      end
      KIND_ADDRE: begin
        c_d.x = ra.x + (XW'($signed(cs.in_re)) <<< GUARD);
      end
      KIND_RECT: begin
        c_d.x = XW'($signed(cs.in_re)) <<< GUARD;
        c_d.y = XW'($signed(cs.in_im)) <<< GUARD;
      end
      KIND_RENORM: begin
        c_d = ra;
      end
      default: begin
        c_d = ra;
      end
    endcase
  end

  // fold left half-plane into the right one before vectoring
  always_comb begin
    vf_d = c_q;
    if (c_q.x[XW-1]) begin
      vf_d.x = -c_q.x;
      vf_d.y = -c_q.y;
      vf_d.z = HALF_TURN;
    end else begin
      vf_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q  <= c_d;
      vf_q <= vf_d;
    end
  end

  pcalu_cordic #(.STEPS(STEPS), .VECT(1'b1)) u_vec (
    .clk_i(clk_i), .en_i(en), .v_i(vf_q), .v_o(rv)
  );

  // gain removal split in two partial products
  always_comb begin
    logic [XW-1:0] xp;
    xp         = rv.x[XW-1] ? '0 : rv.x;
    mk1_d.p1   = 64'(xp[XW-1:16]) * 64'(KGAIN);
    mk1_d.p2   = 48'(xp[15:0]) * 48'(KGAIN);
    mk1_d.turn = rv.z[31:0];
  end

  always_comb begin
    logic [63:0] s;
    logic [63:0] m;
    logic [31:0] tr;
    s  = mk1_q.p1 + 64'(mk1_q.p2[47:16]);
    m  = ((s >> 16) + 64'(RND_G)) >> GUARD;
    tr = mk1_q.turn + 32'h0000_8000;
    mk2_d.mag = (m[63:32] != '0) ? 32'hFFFF_FFFF : m[31:0];
    mk2_d.ang = tr[31:16];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mk1_q <= mk1_d;
      mk2_q <= mk2_d;
    end
  end

  pcalu_pipe #(.W($bits(pol_t)), .DEPTH(LM - LC)) u_calign (
    .clk_i(clk_i), .en_i(en), .d_i(mk2_q), .q_o(cpol)
  );

  // ---------------- direct path: mul, div, negate ----------------
  always_comb begin
    logic [63:0] prod;
    logic [63:0] sh;
    prod        = 64'(s0_q.item.a_mag) * 64'(s0_q.item.b_mag);
    sh          = prod >> FRAC;
    d1_d.direct = s0_q.cls.direct;
    d1_d.is_div = s0_q.cls.is_div;
    d1_d.zdiv   = s0_q.cls.is_div && (s0_q.item.b_mag == '0);
    case (s0_q.item.kind)
      KIND_NEG: begin
        d1_d.mag = s0_q.item.a_mag;
        d1_d.ang = s0_q.item.a_ang + 16'h8000;
      end
      KIND_DIV: begin
        d1_d.mag = '0;
        d1_d.ang = s0_q.item.a_ang - s0_q.item.b_ang;
      end
      default: begin
        d1_d.mag = (sh[63:32] != '0) ? 32'hFFFF_FFFF : sh[31:0];
        d1_d.ang = s0_q.item.a_ang + s0_q.item.b_ang;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q <= d1_d;
    end
  end

  pcalu_div #(.FRAC(FRAC)) u_div (
    .clk_i(clk_i), .en_i(en), .num_i(s0_q.item.a_mag), .den_i(s0_q.item.b_mag),
    .quo_o(quo)
  );

  pcalu_pipe #(.W($bits(dside_t)), .DEPTH(DW - 1)) u_dside (
    .clk_i(clk_i), .en_i(en), .d_i(d1_q), .q_o(ds_al)
  );

  assign dres_in.ds  = ds_al;
  assign dres_in.quo = quo;

  pcalu_pipe #(.W($bits(dres_t)), .DEPTH(LM - DW)) u_dalign (
    .clk_i(clk_i), .en_i(en), .d_i(dres_in), .q_o(dres)
  );

  // ---------------- merge and final rotation ----------------
  always_comb begin
    m_d.zdiv = dres.ds.zdiv;
    if (dres.ds.direct) begin
      m_d.pol.ang = dres.ds.ang;
      if (!dres.ds.is_div) begin
        m_d.pol.mag = dres.ds.mag;
      end else if (dres.ds.zdiv || (dres.quo[DW-1:32] != '0)) begin
        m_d.pol.mag = 32'hFFFF_FFFF;
      end else begin
        m_d.pol.mag = dres.quo[31:0];
      end
    end else begin
      m_d.pol = cpol;
    end
    if (m_d.pol.mag == '0) begin
      m_d.pol.ang = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q <= m_d;
      f_q <= prerot(m_q.pol.mag, m_q.pol.ang);
    end
  end

  pcalu_cordic #(.STEPS(STEPS), .VECT(1'b0)) u_rot_f (
    .clk_i(clk_i), .en_i(en), .v_i(f_q), .v_o(rf)
  );

  pcalu_pipe #(.W($bits(mres_t)), .DEPTH(STEPS + 1)) u_malign (
    .clk_i(clk_i), .en_i(en), .d_i(m_q), .q_o(m_al)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_mag_q  <= m_al.pol.mag;
      o_ang_q  <= m_al.pol.ang;
      o_zdiv_q <= m_al.zdiv;
      o_re_q   <= sat_s32(rf.x);
      o_im_q   <= sat_s32(rf.y);
    end
  end

  assign res_mag_o = o_mag_q;
  assign res_ang_o = o_ang_q;
  assign res_re_o  = o_re_q;
  assign res_im_o  = o_im_q;
  assign zdiv_o    = o_zdiv_q;

endmodule

/* sv/pcalu_chk.sv */
// Port-level checker for the polar complex ALU, bound to the top level.
module pcalu_chk import pcalu_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_i,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  a_zdiv_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i[0] |-> m_axis_tdata_i[31:0] == 32'hFFFF_FFFF)
    else $error("zero divisor without saturated magnitude");

  a_zero_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tdata_i[31:0] == '0) |->
      (m_axis_tdata_i[111:32] == '0))
    else $error("zero magnitude with nonzero angle or parts");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_i)
    else $error("result valid right after reset");

endmodule

bind polar_complex_alu pcalu_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o),
  .m_axis_tuser_i (m_axis_tuser_o)
);
